// File: design/swmc_pkg.sv
// Shared types and constants for the sliding window median cost block.
package swmc_pkg;

    localparam int WINDOW_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_W           = 9;
    localparam int SAMPLE_W        = 32;
    localparam int COST_W          = 40;
    localparam int OUT_TDATA_W     = 48;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_COST
    } swmc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic remove;
        logic insert;
        logic cost;
    } swmc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic out_busy;
    } swmc_status_t;

endpackage

// File: design/swmc_ctrl.sv
// Controller state machine that sequences removal, insertion and cost output.
module swmc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  swmc_pkg::swmc_status_t status,
    output swmc_pkg::swmc_cmd_t    cmd
);
    import swmc_pkg::*;

    swmc_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.full ? ST_REMOVE : ST_INSERT;
                end
            end
            ST_REMOVE: begin
                cmd.remove = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = ST_COST;
            end
            ST_COST: begin
                if (!status.full) begin
                    state_next = ST_IDLE;
                end else if (!status.out_busy) begin
                    cmd.cost   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/swmc_dp.sv
// Datapath: arrival ring, sorted cell chain, running sums and output register.
module swmc_dp #(
    parameter int WINDOW_MAX  = swmc_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [swmc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [swmc_pkg::SAMPLE_W-1:0]       s_sample,
    input  swmc_pkg::swmc_cmd_t                 cmd,
    output swmc_pkg::swmc_status_t              status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swmc_pkg::COST_W-1:0]         m_cost
);
    import swmc_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int WIDE_W = (SUM_W + 1 > COST_W) ? SUM_W + 1 : COST_W + 1;

    logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_reg [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_next [WINDOW_MAX];
    logic [CFG_W-1:0]       wsize_reg;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [SUM_W-1:0]       tot_reg, tot_next;
    logic [SUM_W-1:0]       low_reg, low_next;
    logic [SAMPLE_BITS-1:0] smp_reg, old_reg;
    logic                   m_tvalid_reg;
    logic [COST_W-1:0]      cost_reg;

    logic [CNT_W-1:0]       w_eff, lcnt;
    logic [SAMPLE_BITS-1:0] a_lm1, a_l;
    logic [WINDOW_MAX-1:0]  gt_vec, ge_vec;
    logic                   gt_l, rm_low;
    logic [SUM_W-1:0]       low_rm;
    logic [WIDE_W-1:0]      cost_wide;

    // Effective window length: zero counts as one, large values saturate.
    always_comb begin
        if (wsize_reg == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(wsize_reg) > 32'(WINDOW_MAX)) begin
            w_eff = CNT_W'(WINDOW_MAX);
        end else begin
            w_eff = CNT_W'(wsize_reg);
        end
    end

    assign lcnt            = CNT_W'((fill_reg + 1'b1) >> 1);
    assign status.full     = (fill_reg == w_eff);
    assign status.out_busy = m_tvalid_reg && !m_tready;

    // Per-cell compares and selection of the cells around the median.
    always_comb begin
        a_lm1 = '0;
        a_l   = '0;
        gt_l  = 1'b1;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            gt_vec[i] = (CNT_W'(i) >= fill_reg) || (cell_reg[i] > smp_reg);
            ge_vec[i] = (cell_reg[i] >= old_reg);
            if (CNT_W'(i) + 1'b1 == lcnt) begin
                a_lm1 = cell_reg[i];
            end
            if (CNT_W'(i) == lcnt) begin
                a_l  = cell_reg[i];
                gt_l = gt_vec[i];
            end
        end
    end

    // Cell chain update: shift down over the leaving sample, or up to open a slot.
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.remove) begin
                if (ge_vec[i] && i + 1 < WINDOW_MAX) begin
                    cell_next[i] = cell_reg[(i + 1) % WINDOW_MAX];
                end
            end else if (cmd.insert && gt_vec[i]) begin
                if (i == 0) begin
                    cell_next[i] = smp_reg;
                end else if (!gt_vec[(i + WINDOW_MAX - 1) % WINDOW_MAX]) begin
                    cell_next[i] = smp_reg;
                end else begin
                    cell_next[i] = cell_reg[(i + WINDOW_MAX - 1) % WINDOW_MAX];
                end
            end
        end
    end

    // Lower half sum after removal of the leaving sample.
    assign rm_low = (old_reg <= a_lm1);
    assign low_rm = rm_low ? low_reg - SUM_W'(old_reg) : low_reg - SUM_W'(a_lm1);

    // Counters and running sums.
    always_comb begin
        fill_next = fill_reg;
        pos_next  = pos_reg;
        tot_next  = tot_reg;
        low_next  = low_reg;
        if (cmd.remove) begin
            fill_next = fill_reg - 1'b1;
            tot_next  = tot_reg - SUM_W'(old_reg);
            if (fill_reg[0]) begin
                low_next = low_rm;
            end else begin
                low_next = low_rm + SUM_W'(rm_low ? a_l : a_lm1);
            end
        end else if (cmd.insert) begin
            fill_next = fill_reg + 1'b1;
            tot_next  = tot_reg + SUM_W'(smp_reg);
            pos_next  = (CNT_W'(pos_reg) + 1'b1 == w_eff) ? '0 : pos_reg + 1'b1;
            if (!fill_reg[0]) begin
                low_next = gt_l ? low_reg + SUM_W'(smp_reg) : low_reg + SUM_W'(a_l);
            end else if (a_lm1 > smp_reg) begin
                low_next = low_reg + SUM_W'(smp_reg) - SUM_W'(a_lm1);
            end
        end
    end

    // Deviation sum: total minus twice the lower half, plus the median for odd counts.
    always_comb begin
        cost_wide = WIDE_W'(tot_reg) - (WIDE_W'(low_reg) << 1)
                  + WIDE_W'(fill_reg[0] ? a_lm1 : '0);
        if (cost_wide > WIDE_W'({COST_W{1'b1}})) begin
            cost_wide = WIDE_W'({COST_W{1'b1}});
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg    <= CFG_W'(1);
            fill_reg     <= '0;
            pos_reg      <= '0;
            tot_reg      <= '0;
            low_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                wsize_reg <= cfg_wdata;
                fill_reg  <= '0;
                pos_reg   <= '0;
                tot_reg   <= '0;
                low_reg   <= '0;
            end else begin
                fill_reg <= fill_next;
                pos_reg  <= pos_next;
                tot_reg  <= tot_next;
                low_reg  <= low_next;
            end
            if (cmd.cost) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, cells and the arrival ring.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            smp_reg <= SAMPLE_BITS'(s_sample);
            old_reg <= ring[pos_reg];
        end
        if (cmd.insert) begin
            ring[pos_reg] <= smp_reg;
        end
        if (cmd.cost) begin
            cost_reg <= COST_W'(cost_wide);
        end
        for (int i = 0; i < WINDOW_MAX; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_cost   = cost_reg;

endmodule

// File: design/sliding_window_median_cost_top.sv
// Top level of the sliding window median cost block.
// The block takes one unsigned sample per transaction on the s_ channel and keeps
// the most recent window_size samples in an arrival ring and a sorted cell chain.
// Once the window is full, each sample yields one transaction on the m_ channel
// carrying the sum of absolute deviations from the lower median; before that no
// result is given. cfg_we writes window_size and empties the window.
// When the window is full an item passes through accept, removal of the leaving
// sample from the cell chain, insertion of the new one and the cost step; while
// the window fills, removal is skipped. The cell chain's one-change-per-cycle
// updates set this. The result is on m_tdata in the cycle after the cost step and
// sits in an output register, so the next sample is accepted while it waits. If the
// receiver stalls, a new result waits in the cost step until the register is free.
// Reset clears the window, sets window_size to 1 and drops m_tvalid.
module sliding_window_median_cost_top #(
    parameter int WINDOW_MAX  = swmc_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [swmc_pkg::CFG_W-1:0]          cfg_wdata,    // window_size
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [swmc_pkg::SAMPLE_W-1:0]       s_tdata,      // sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swmc_pkg::OUT_TDATA_W-1:0]    m_tdata       // cost, then zero pad
);
    import swmc_pkg::*;

    swmc_cmd_t         cmd;
    swmc_status_t      status;
    logic [COST_W-1:0] cost;

    swmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swmc_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_sample  (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_cost    (cost)
    );

    assign m_tdata = {{(OUT_TDATA_W - COST_W){1'b0}}, cost};

endmodule

// File: design/swmc_checker.sv
// Port checker for the sliding window median cost block, bound to the top level.
module swmc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [swmc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import swmc_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // One sample is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while busy");

    // Padding above the cost stays zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:COST_W] == '0)
        else $error("padding bits set");

endmodule

bind sliding_window_median_cost_top swmc_checker u_swmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/sliding_window_median_cost_top_tb.sv
// Self-checking testbench for the sliding window median cost block.
module sliding_window_median_cost_top_tb;
    import swmc_pkg::*;

    localparam int WMAX        = WINDOW_MAX_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    // Predicts deviation sums and checks results against them in order.
    class cost_scoreboard;
        int unsigned win_len;
        int unsigned fill;
        int unsigned wpos;
        logic [SAMPLE_W-1:0] ring [WMAX];
        logic [SAMPLE_W-1:0] sorted_q [$];
        logic [COST_W-1:0] pending_costs [$];
        int unsigned errors;

        function void set_window(logic [CFG_W-1:0] value);
            if (value == 0) begin
                win_len = 1;
            end else if (value > WMAX) begin
                win_len = WMAX;
            end else begin
                win_len = value;
            end
            fill = 0;
            wpos = 0;
            sorted_q.delete();
        endfunction

        // Notes an accepted sample and queues the cost it causes, if any.
        function void note_sample(logic [SAMPLE_W-1:0] smp);
            int unsigned lcount;
            int unsigned at;
            logic [63:0] med;
            logic [63:0] lo_sum;
            logic [63:0] hi_sum;
            logic [63:0] total;
            if (wpos >= win_len) wpos = 0;
            if (fill >= win_len) begin
                at = sorted_q.size() - 1;
                foreach (sorted_q[i]) begin
                    if (sorted_q[i] == ring[wpos]) begin
                        at = i;
                        break;
                    end
                end
                sorted_q.delete(at);
                fill = win_len - 1;
            end
            at = 0;
            while (at < sorted_q.size() && sorted_q[at] <= smp) at++;
            sorted_q.insert(at, smp);
            fill++;
            ring[wpos] = smp;
            wpos = (wpos + 1 == win_len) ? 0 : wpos + 1;
            if (fill < win_len) return;
            lcount = (fill + 1) / 2;
            lo_sum = 0;
            hi_sum = 0;
            foreach (sorted_q[i]) begin
                if (i < lcount) lo_sum += sorted_q[i];
                else hi_sum += sorted_q[i];
            end
            med = sorted_q[lcount - 1];
            total = (hi_sum - (fill - lcount) * med) + (lcount * med - lo_sum);
            if (total > 64'hFF_FFFF_FFFF) total = 64'hFF_FFFF_FFFF;
            pending_costs = {pending_costs, total[COST_W-1:0]};
        endfunction

        // Checks one accepted result against the oldest expected cost.
        function void check_cost(logic [OUT_TDATA_W-1:0] word);
            logic [COST_W-1:0] want;
            if (pending_costs.size() == 0) begin
                $error("cost: unexpected result %0d", word[COST_W-1:0]);
                errors++;
                return;
            end
            want = pending_costs.pop_front();
            if (word[COST_W-1:0] !== want) begin
                $error("cost: expected %0d, actual %0d", want, word[COST_W-1:0]);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata;      // sample
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;      // cost, then zero pad

    cost_scoreboard sb;
    int unsigned    cycle_count;
    int unsigned    stall_mode;

    sliding_window_median_cost_top u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Cycle limit as a guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sliding_window_median_cost_top regression: fail");
            $finish;
        end
    end

    // Receiver: stalls on a pattern that changes every so often.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= cycle_count[2];
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_cost(m_tdata);
    end

    // Sends one sample and waits for its transaction to be accepted.
    task automatic send_sample(logic [SAMPLE_W-1:0] smp);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(smp);
    endtask

    // Drops valid for a random gap, or keeps it up within a burst.
    task automatic sender_gap(inout int burst_left);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
        burst_left = $urandom_range(0, 20);
    endtask

    // Waits for every expected result and lets the block settle, then writes.
    task automatic write_window(logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_costs.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_window(value);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            3: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Main stimulus.
    initial begin
        logic [CFG_W-1:0] sizes [$];
        int burst_left;
        int per_phase;
        sb = new();
        sb.set_window(9'd1);
        cycle_count = 0;
        stall_mode  = 0;
        burst_left  = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset window of one, extreme samples.
        send_sample(32'h0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h5555_5555);
        // Window of zero acts as one.
        write_window(9'd0);
        send_sample(32'hAAAA_AAAA);
        send_sample(32'h1);
        // Even window with duplicates and extremes.
        write_window(9'd4);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0);
        send_sample(32'h7);
        send_sample(32'h7);
        write_window(9'd3);
        send_sample(32'h10);
        send_sample(32'h10);
        send_sample(32'h10);
        send_sample(32'h2);
        s_tvalid <= 1'b0;

        // Random phases over several sizes, the extremes among them.
        sizes = '{9'd511, 9'd256, 9'd1, 9'd2, 9'd5, 9'd16, 9'd255, 9'd0, 9'd7, 9'd64, 9'd300,
                  9'd3, 9'd33, 9'd8};
        foreach (sizes[k]) begin
            write_window(sizes[k]);
            per_phase = (sizes[k] >= 200) ? 270 : 30 + int'(sizes[k]);
            repeat (per_phase) begin
                send_sample(rand_sample());
                sender_gap(burst_left);
            end
        end
        s_tvalid <= 1'b0;

        // Drain and finish.
        @(posedge aclk);
        while (sb.pending_costs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("sliding_window_median_cost_top regression: pass");
        end else begin
            $display("sliding_window_median_cost_top regression: fail");
        end
        $finish;
    end
endmodule
